// ----- rtl/spknn_pkg.sv -----
// Shared types and constants for the k-nearest splat pixel selector.
package spknn_pkg;

  localparam int ONE_Q12  = 4096;
  localparam int MAX_SIDE = 1024;

  localparam logic CMD_POINT = 1'b0;
  localparam logic CMD_END   = 1'b1;

  localparam logic [1:0] REG_SIDE_LEN  = 2'd0;
  localparam logic [1:0] REG_MERGE_THR = 2'd1;

  typedef struct packed {
    logic               is_end;
    logic signed [23:0] depth;
    logic [19:0]        id;
    logic signed [31:0] q;
  } job_t;

endpackage

// ----- rtl/spknn_centre.sv -----
// Pixel centre table: divides (2*rev+1)*8192+s by 2*s with a shift-subtract unit.
module spknn_centre (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [10:0]         size,
  input  logic [9:0]          idx,
  output logic                done,
  output logic signed [15:0]  centre
);

  localparam int NW = 24;
  localparam int ONE_LOCAL = spknn_pkg::ONE_Q12;

  logic [NW-1:0] num;
  logic [NW-1:0] quo;
  logic [NW:0]   rem;
  logic [NW:0]   den;
  logic [4:0]    cnt;
  logic          busy;
  logic [NW:0]   rem_sh;
  logic [11:0]   rev;

  always_comb begin
    if ({1'b0, size} > {2'b0, idx} + 12'd1) begin
      rev = {1'b0, size} - 12'd1 - {2'b0, idx};
    end else begin
      rev = '0;
    end
    rem_sh = {rem[NW-1:0], num[NW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(NW);
        num  <= (((NW'(rev) << 1) + NW'(1)) << 13) + NW'(size);
        den  <= (NW+1)'(size) << 1;
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        num <= num << 1;
        if (rem_sh >= den) begin
          rem <= rem_sh - den;
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[NW-2:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign centre = 16'(quo) - 16'(ONE_LOCAL);

endmodule

// ----- rtl/spknn_front.sv -----
// Front: point test state machine (box, quadratic form, cutoff) handing jobs to the back.
module spknn_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               ready,
  input  logic               command,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic signed [23:0] point_depth,
  input  logic [14:0]        radius_x,
  input  logic [14:0]        radius_y,
  input  logic signed [23:0] ellipse_a,
  input  logic signed [23:0] ellipse_b,
  input  logic signed [23:0] ellipse_c,
  input  logic signed [31:0] cutoff,
  input  logic [19:0]        point_id,
  input  logic signed [15:0] cx,
  input  logic signed [15:0] cy,
  input  logic               centre_ok,
  output logic               job_valid,
  input  logic               job_ready,
  output spknn_pkg::job_t    job
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQ   = 5'b00010,
    S_MUL  = 5'b00100,
    S_SUM  = 5'b01000,
    S_OUT  = 5'b10000
  } fstate_t;

  fstate_t state;
  logic signed [17:0] dx, dy;
  logic signed [35:0] pxx, pxy, pyy;
  logic signed [59:0] ta, tb, tc;
  logic signed [61:0] sum;
  logic signed [23:0] a, b, c, depth;
  logic signed [31:0] cut;
  logic [19:0]        id;
  logic               keep;
  logic signed [37:0] qf;
  logic signed [31:0] qs;
  logic signed [17:0] dxn, dyn;
  logic [17:0]        adx, ady;

  always_comb begin
    dxn = 18'(cx) - 18'(point_x);
    dyn = 18'(cy) - 18'(point_y);
    adx = dxn[17] ? 18'(-dxn) : 18'(dxn);
    ady = dyn[17] ? 18'(-dyn) : 18'(dyn);
    qf  = 38'(sum >>> 24);
    if (qf > 38'sd2147483647) begin
      qs = 32'sh7fffffff;
    end else if (qf < -38'sd2147483648) begin
      qs = 32'sh80000000;
    end else begin
      qs = 32'(qf);
    end
  end

  assign ready = (state == S_IDLE) && centre_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      job_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (valid && ready) begin
            dx <= dxn;
            dy <= dyn;
            a <= ellipse_a;
            b <= ellipse_b;
            c <= ellipse_c;
            depth <= point_depth;
            cut <= cutoff;
            id <= point_id;
            if (command == spknn_pkg::CMD_END) begin
              job.is_end <= 1'b1;
              job_valid  <= 1'b1;
              state      <= S_OUT;
            end else begin
              keep <= !point_depth[23] && adx <= {3'b0, radius_x} && ady <= {3'b0, radius_y};
              state <= S_SQ;
            end
          end
        end
        S_SQ: begin
          pxx <= dx * dx;
          pxy <= dx * dy;
          pyy <= dy * dy;
          state <= S_MUL;
        end
        S_MUL: begin
          ta <= a * pxx;
          tb <= b * pxy;
          tc <= c * pyy;
          state <= S_SUM;
        end
        S_SUM: begin
          sum <= 62'(ta) + 62'(tb) + 62'(tc);
          state <= S_OUT;
          job.is_end <= 1'b0;
        end
        S_OUT: begin
          if (!job.is_end && !job_valid) begin
            if (keep && !(qs > cut)) begin
              job.depth <= depth;
              job.id    <= id;
              job.q     <= qs;
              job_valid <= 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end else if (job_valid && job_ready) begin
            job_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/spknn_back.sv -----
// Back: shifting sorted slot list, merge pruning and per-pixel emission.
module spknn_back #(
  parameter int SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_ready,
  input  spknn_pkg::job_t    job,
  input  logic signed [23:0] merge_thr,
  input  logic [9:0]         cur_col,
  input  logic [9:0]         cur_row,
  output logic               pixel_done,
  output logic               valid,
  input  logic               ready,
  output logic [9:0]         pixel_col,
  output logic [9:0]         pixel_row,
  output logic [5:0]         slot,
  output logic               slot_valid,
  output logic [19:0]        hit_id,
  output logic signed [23:0] hit_depth,
  output logic signed [31:0] hit_q,
  output logic               occupied,
  output logic               last
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_PRUNE = 3'b010,
    B_EMIT  = 3'b100
  } bstate_t;

  bstate_t state;
  logic              used [SLOTS];
  logic signed [23:0] sd [SLOTS];
  logic [19:0]       si [SLOTS];
  logic signed [31:0] sq [SLOTS];
  logic [SLOTS-1:0]  lt;
  logic [SW-1:0]     ek;
  logic              occ;
  logic signed [24:0] gap [SLOTS];

  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      lt[k] = !used[k] || (job.depth < sd[k]) ||
              (job.depth == sd[k] && (job.id < si[k] || (job.id == si[k] && job.q < sq[k])));
      gap[k] = 25'(sd[k]) - 25'(sd[0]);
    end
  end

  assign job_ready = (state == B_IDLE) && !job_valid ? 1'b0 : (state == B_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      valid      <= 1'b0;
      pixel_done <= 1'b0;
      for (int k = 0; k < SLOTS; k++) used[k] <= 1'b0;
    end else begin
      pixel_done <= 1'b0;
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            if (job.is_end) begin
              state <= B_PRUNE;
            end else begin
              if (lt[0]) begin
                used[0] <= 1'b1;
                sd[0] <= job.depth;
                si[0] <= job.id;
                sq[0] <= job.q;
              end
              for (int k = 1; k < SLOTS; k++) begin
                if (lt[k] && !lt[k-1]) begin
                  used[k] <= 1'b1;
                  sd[k] <= job.depth;
                  si[k] <= job.id;
                  sq[k] <= job.q;
                end else if (lt[k-1]) begin
                  used[k] <= used[k-1];
                  sd[k] <= sd[k-1];
                  si[k] <= si[k-1];
                  sq[k] <= sq[k-1];
                end
              end
            end
          end
        end
        B_PRUNE: begin
          occ <= used[0];
          for (int k = 1; k < SLOTS; k++) begin
            if (used[0] && gap[k] > 25'(merge_thr)) used[k] <= 1'b0;
          end
          ek    <= '0;
          state <= B_EMIT;
        end
        B_EMIT: begin
          if (!valid || ready) begin
            valid      <= 1'b1;
            pixel_col  <= cur_col;
            pixel_row  <= cur_row;
            slot       <= 6'(ek);
            slot_valid <= used[ek];
            hit_id     <= used[ek] ? si[ek] : '0;
            hit_depth  <= used[ek] ? sd[ek] : '0;
            hit_q      <= used[ek] ? sq[ek] : '0;
            occupied   <= occ;
            last       <= (32'(ek) == SLOTS - 1);
            used[ek]   <= 1'b0;
            if (32'(ek) == SLOTS - 1) begin
              state      <= B_IDLE;
              pixel_done <= 1'b1;
            end else begin
              ek <= ek + SW'(1);
            end
          end
        end
        default: state <= B_IDLE;
      endcase
      if (valid && ready && !(state == B_EMIT)) valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/splat_k_nearest_pixel_select_core.sv -----
// Top level of the k-nearest splat pixel selector.
// A candidate is tested in the front's S_SQ, S_MUL, S_SUM and S_OUT states and, when kept,
// is then handed to the slot list; an end of pixel goes to the back's prune and emit states.
// The front takes no new candidate until it is done with the last; an end of pixel holds
// the input while every slot is emitted (output stalls extend this) and the centre division
// runs; a side length write also triggers the centre recompute.
// Reset (rst, synchronous, active high): counters zero, slots empty, registers at defaults.
module splat_k_nearest_pixel_select_core #(
  parameter int SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               valid,
  output logic               ready,
  input  logic               command,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic signed [23:0] point_depth,
  input  logic [14:0]        radius_x,
  input  logic [14:0]        radius_y,
  input  logic signed [23:0] ellipse_a,
  input  logic signed [23:0] ellipse_b,
  input  logic signed [23:0] ellipse_c,
  input  logic signed [31:0] cutoff,
  input  logic [19:0]        point_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         pixel_col,
  output logic [9:0]         pixel_row,
  output logic [5:0]         slot,
  output logic               slot_valid,
  output logic [19:0]        hit_id,
  output logic signed [23:0] hit_depth,
  output logic signed [31:0] hit_q,
  output logic               occupied,
  output logic               last
);

  logic [10:0]        side_len;
  logic signed [23:0] merge_thr;
  logic [10:0]        eff;
  logic [9:0]         col, row;
  logic               pixel_done, job_valid, job_ready;
  spknn_pkg::job_t    job;
  logic               start, cdone_x, cdone_y, ok, pend;
  logic               ok_next, pend_next, size_wr, in_end;
  logic signed [15:0] cx, cy;
  logic               wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign size_wr = wr && paddr[2] == spknn_pkg::REG_SIDE_LEN[0];
  assign in_end = valid && ready && command == spknn_pkg::CMD_END;
  assign prdata = (paddr[2] == spknn_pkg::REG_MERGE_THR[0]) ? {{8{merge_thr[23]}}, merge_thr}
                                                           : {21'b0, side_len};

  always_comb begin
    if (side_len == 11'd0) eff = 11'd1;
    else if (32'(side_len) > spknn_pkg::MAX_SIDE) eff = 11'(spknn_pkg::MAX_SIDE);
    else eff = side_len;
  end

  always_comb begin
    pend_next = size_wr || pixel_done;
    if (size_wr || pixel_done || in_end) ok_next = 1'b0;
    else if (cdone_x) ok_next = 1'b1;
    else ok_next = ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_len <= 11'd256;
      merge_thr  <= 24'sd4096;
      col <= '0;
      row <= '0;
      ok  <= 1'b0;
      pend <= 1'b1;
    end else begin
      pend <= pend_next;
      ok   <= ok_next;
      if (size_wr) begin
        side_len <= pwdata[10:0];
      end else if (wr && paddr[2] == spknn_pkg::REG_MERGE_THR[0]) begin
        merge_thr <= pwdata[23:0];
      end
      if (pixel_done) begin
        if ({1'b0, col} + 11'd1 >= eff) begin
          col <= '0;
          row <= ({1'b0, row} + 11'd1 >= eff) ? '0 : row + 10'd1;
        end else begin
          col <= col + 10'd1;
        end
      end
    end
  end

  assign start = pend;

  spknn_centre u_cx (
    .clk(clk), .rst(rst), .start(start), .size(eff), .idx(col),
    .done(cdone_x), .centre(cx)
  );

  spknn_centre u_cy (
    .clk(clk), .rst(rst), .start(start), .size(eff), .idx(row),
    .done(cdone_y), .centre(cy)
  );

  spknn_front u_front (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready), .command(command),
    .point_x(point_x), .point_y(point_y), .point_depth(point_depth),
    .radius_x(radius_x), .radius_y(radius_y), .ellipse_a(ellipse_a),
    .ellipse_b(ellipse_b), .ellipse_c(ellipse_c), .cutoff(cutoff),
    .point_id(point_id), .cx(cx), .cy(cy), .centre_ok(ok && !cdone_y && !pend),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  spknn_back #(.SLOTS(SLOTS)) u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job_ready(job_ready), .job(job),
    .merge_thr(merge_thr), .cur_col(col), .cur_row(row), .pixel_done(pixel_done),
    .valid(out_valid), .ready(out_ready), .pixel_col(pixel_col), .pixel_row(pixel_row),
    .slot(slot), .slot_valid(slot_valid), .hit_id(hit_id), .hit_depth(hit_depth),
    .hit_q(hit_q), .occupied(occupied), .last(last)
  );

endmodule

// ----- rtl/spknn_checker.sv -----
// Port-level checks for the k-nearest splat pixel selector.
module spknn_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        slot_valid,
  input logic [19:0] hit_id,
  input logic        occupied,
  input logic [5:0]  slot,
  input logic        pready
);

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !slot_valid |-> hit_id == 20'd0) else $error("empty slot id");
  a_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && slot == 6'd0 |-> occupied == slot_valid) else $error("occupied");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(slot)) else $error("hold");
  a_pready: assert property (@(posedge clk) pready) else $error("pready");

endmodule

bind splat_k_nearest_pixel_select_core spknn_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .slot_valid(slot_valid), .hit_id(hit_id), .occupied(occupied), .slot(slot),
  .pready(pready)
);

// ----- tb/sv/tb_top.sv -----
// Testbench for the k-nearest splat pixel selector: directed and random pixel streams.
`timescale 1ns / 100ps

module tb_top;

  localparam int SLOTS = 8;
  localparam int LIMIT = 1500000;
  localparam int SETTLE = 40;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [23:0] depth;
    logic [14:0]        rx;
    logic [14:0]        ry;
    logic signed [23:0] a;
    logic signed [23:0] b;
    logic signed [23:0] c;
    logic signed [31:0] cut;
    logic [19:0]        id;
  } splat_req_t;

  typedef struct packed {
    logic [9:0]         col;
    logic [9:0]         row;
    logic [5:0]         slot;
    logic               valid;
    logic [19:0]        id;
    logic signed [23:0] depth;
    logic signed [31:0] q;
    logic               occ;
    logic               last;
  } slot_hit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic valid = 1'b0;
  logic ready;
  splat_req_t req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [9:0] pixel_col, pixel_row;
  logic [5:0] slot;
  logic slot_valid, occupied, last;
  logic [19:0] hit_id;
  logic signed [23:0] hit_depth;
  logic signed [31:0] hit_q;

  splat_k_nearest_pixel_select_core u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .valid, .ready,
    .command(req.cmd), .point_x(req.px), .point_y(req.py), .point_depth(req.depth),
    .radius_x(req.rx), .radius_y(req.ry), .ellipse_a(req.a), .ellipse_b(req.b),
    .ellipse_c(req.c), .cutoff(req.cut), .point_id(req.id),
    .out_valid, .out_ready, .pixel_col, .pixel_row, .slot, .slot_valid,
    .hit_id, .hit_depth, .hit_q, .occupied, .last
  );

  always #5 clk = ~clk;

  // model state
  int unsigned img_size;
  longint merge_thr;
  int col_cnt, row_cnt;
  logic slot_used[SLOTS];
  longint slot_depth[SLOTS];
  logic [19:0] slot_id[SLOTS];
  longint slot_q[SLOTS];
  slot_hit_t pixel_hits_q[$];

  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;
  int held = 0;

  function automatic int eff_size();
    if (img_size == 0) return 1;
    if (img_size > spknn_pkg::MAX_SIDE) return spknn_pkg::MAX_SIDE;
    return img_size;
  endfunction

  function automatic longint pixel_centre(int idx);
    longint s, rev, num;
    s = eff_size();
    rev = s - 1 - idx;
    if (rev < 0) rev = 0;
    num = (2 * rev + 1) * 2 * spknn_pkg::ONE_Q12 + s;
    return num / (2 * s) - spknn_pkg::ONE_Q12;
  endfunction

  function automatic bit key_less(longint d1, logic [19:0] i1, longint q1,
                                  longint d2, logic [19:0] i2, longint q2);
    if (d1 != d2) return d1 < d2;
    if (i1 != i2) return i1 < i2;
    return q1 < q2;
  endfunction

  function automatic splat_req_t rand_req();
    logic [223:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return splat_req_t'(bits[$bits(splat_req_t)-1:0]);
  endfunction

  function automatic void clear_slots();
    for (int k = 0; k < SLOTS; k++) begin
      slot_used[k] = 1'b0;
      slot_depth[k] = 0;
      slot_id[k] = 0;
      slot_q[k] = 0;
    end
  endfunction

  function automatic void nearest_insert(splat_req_t r);
    longint dx, dy, sum, q, d;
    int n, pos, k;
    d = r.depth;
    if (d < 0) return;
    dx = pixel_centre(col_cnt) - longint'(r.px);
    dy = pixel_centre(row_cnt) - longint'(r.py);
    if ((dx < 0 ? -dx : dx) > longint'(r.rx) ||
        (dy < 0 ? -dy : dy) > longint'(r.ry)) return;
    sum = longint'(r.a) * (dx * dx) + longint'(r.b) * (dx * dy) + longint'(r.c) * (dy * dy);
    q = sum >>> 24;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    if (q > longint'(r.cut)) return;
    n = 0;
    while (n < SLOTS && slot_used[n]) n++;
    pos = n;
    while (pos > 0 && key_less(d, r.id, q, slot_depth[pos-1], slot_id[pos-1], slot_q[pos-1]))
      pos--;
    if (pos >= SLOTS) return;
    for (k = (n < SLOTS) ? n : SLOTS - 1; k > pos; k--) begin
      slot_used[k] = slot_used[k-1];
      slot_depth[k] = slot_depth[k-1];
      slot_id[k] = slot_id[k-1];
      slot_q[k] = slot_q[k-1];
    end
    slot_used[pos] = 1'b1;
    slot_depth[pos] = d;
    slot_id[pos] = r.id;
    slot_q[pos] = q;
  endfunction

  function automatic void close_pixel();
    slot_hit_t h;
    logic occ;
    occ = slot_used[0];
    if (occ) begin
      for (int k = 1; k < SLOTS; k++)
        if (slot_used[k] && (slot_depth[k] - slot_depth[0]) > merge_thr) slot_used[k] = 1'b0;
    end
    for (int k = 0; k < SLOTS; k++) begin
      h.col = col_cnt[9:0];
      h.row = row_cnt[9:0];
      h.slot = k[5:0];
      h.valid = slot_used[k];
      h.id = slot_used[k] ? slot_id[k] : '0;
      h.depth = slot_used[k] ? slot_depth[k][23:0] : '0;
      h.q = slot_used[k] ? slot_q[k][31:0] : '0;
      h.occ = occ;
      h.last = (k == SLOTS - 1);
      pixel_hits_q.push_back(h);
    end
    clear_slots();
    if (col_cnt + 1 >= eff_size()) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= eff_size()) ? 0 : row_cnt + 1;
    end else begin
      col_cnt++;
    end
  endfunction

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic send_request(input splat_req_t r);
    req = r;
    valid = 1'b1;
    do @(posedge clk); while (!ready);
    if (r.cmd == spknn_pkg::CMD_END) close_pixel();
    else nearest_insert(r);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      valid = 1'b0;
      req = rand_req();
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
  endtask

  task automatic drain();
    valid = 1'b0;
    while (pixel_hits_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    drain();
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = 3'(idx) << 2;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (idx == spknn_pkg::REG_SIDE_LEN) img_size = 32'(data[10:0]);
    else merge_thr = longint'(signed'(data[23:0]));
  endtask

  function automatic splat_req_t end_req();
    splat_req_t r;
    r = rand_req();
    r.cmd = spknn_pkg::CMD_END;
    return r;
  endfunction

  // candidate aimed at the current pixel, offset within spread
  function automatic splat_req_t aimed_req(int spread);
    splat_req_t r;
    longint cx, cy;
    r = rand_req();
    r.cmd = spknn_pkg::CMD_POINT;
    cx = pixel_centre(col_cnt);
    cy = pixel_centre(row_cnt);
    r.px = 16'(cx + $signed($urandom_range(2 * spread)) - spread);
    r.py = 16'(cy + $signed($urandom_range(2 * spread)) - spread);
    r.rx = 15'(spread + $urandom_range(3));
    r.ry = 15'(spread + $urandom_range(3));
    if ($urandom_range(9) < 8) r.depth = 24'($urandom_range(40000));
    if ($urandom_range(9) < 6) begin
      r.a = 24'($urandom_range(9000));
      r.b = 24'($signed($urandom_range(8000)) - 4000);
      r.c = 24'($urandom_range(9000));
      r.cut = 32'($urandom_range(20000000));
    end
    if ($urandom_range(3) != 0) r.id = 20'($urandom_range(15));
    return r;
  endfunction

  task automatic test_directed_points();
    splat_req_t r;
    r = aimed_req(0);
    r.rx = '0; r.ry = '0;
    r.px = 16'(pixel_centre(col_cnt)); r.py = 16'(pixel_centre(row_cnt));
    r.depth = 24'sh7FFFFF; r.a = 24'sh7FFFFF; r.b = 24'sh800000; r.c = 24'sh7FFFFF;
    r.cut = 32'sh7FFFFFFF; r.id = 20'hFFFFF;
    send_request(r);
    r.depth = '0; r.id = '0; send_request(r);
    send_request(r);
    r.depth = 24'sh800000; send_request(r);
    r.depth = 24'sd5; r.cut = 32'sh80000000; send_request(r);
    r.cut = '0; r.px = r.px + 16'sd1; send_request(r);
    r.px = 16'sh8000; r.py = 16'sh7FFF; r.rx = 15'h7FFF; r.ry = 15'h7FFF;
    r.a = 24'sh800000; r.b = 24'sh7FFFFF; r.c = 24'sh800000; r.cut = 32'sh80000000;
    send_request(r);
    r.a = 24'sh7FFFFF; r.b = 24'sh7FFFFF; r.c = 24'sh7FFFFF; r.cut = 32'sh7FFFFFFF;
    r.depth = 24'sd3; send_request(r);
    send_request(end_req());
  endtask

  task automatic test_overflow_and_merge();
    splat_req_t r;
    for (int i = 0; i < 10; i++) begin
      r = aimed_req(100);
      r.depth = 24'(5000 - i * 400); r.cut = 32'sh7FFFFFFF; r.a = '0; r.b = '0; r.c = '0;
      send_request(r);
    end
    send_request(end_req());
    write_reg(spknn_pkg::REG_MERGE_THR, 32'hFF800000);
    for (int i = 0; i < 3; i++) begin
      r = aimed_req(0);
      r.depth = 24'(i); r.cut = 32'sh7FFFFFFF; r.a = '0; r.b = '0; r.c = '0;
      send_request(r);
    end
    send_request(end_req());
    write_reg(spknn_pkg::REG_MERGE_THR, 32'h007FFFFF);
  endtask

  task automatic test_size_edges();
    write_reg(spknn_pkg::REG_SIDE_LEN, 4);
    repeat (6) send_request(end_req());
    write_reg(spknn_pkg::REG_SIDE_LEN, 0);
    send_request(aimed_req(0));
    repeat (2) send_request(end_req());
    write_reg(spknn_pkg::REG_SIDE_LEN, 32'h7FF);
    send_request(aimed_req(8));
    send_request(end_req());
  endtask

  task automatic test_random_pixels(input int items, input int idle, input int stall);
    int sent;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) == 0) begin
        send_request(rand_req());
        sent++;
      end else begin
        repeat ($urandom_range(SLOTS + 3)) begin
          send_request(aimed_req($urandom_range(1) ? 64 : 3000));
          sent++;
        end
        send_request(end_req());
        sent++;
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    hold_len = 600;
    repeat (12) begin
      send_request(aimed_req(64));
      send_request(end_req());
    end
    drain();
  endtask

  always @(negedge clk) begin
    if (held < hold_len) begin
      out_ready <= 1'b0;
      held <= held + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    slot_hit_t got, exp;
    if (!rst && out_valid && out_ready) begin
      got = {pixel_col, pixel_row, slot, slot_valid, hit_id, hit_depth, hit_q, occupied, last};
      if (pixel_hits_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
      end else begin
        exp = pixel_hits_q.pop_front();
        if (got !== exp)
          report($sformatf({"col %0d/%0d row %0d/%0d slot %0d/%0d v %b/%b id %h/%h ",
                            "d %h/%h q %h/%h occ %b/%b last %b/%b"},
            got.col, exp.col, got.row, exp.row, got.slot, exp.slot, got.valid, exp.valid,
            got.id, exp.id, got.depth, exp.depth, got.q, exp.q, got.occ, exp.occ,
            got.last, exp.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    img_size = 256;
    merge_thr = 4096;
    col_cnt = 0;
    row_cnt = 0;
    clear_slots();
    repeat (10) @(negedge clk);
    rst = 1'b0;
    repeat (SETTLE) @(negedge clk);
    test_directed_points();
    test_overflow_and_merge();
    test_size_edges();
    write_reg(spknn_pkg::REG_SIDE_LEN, 3);
    write_reg(spknn_pkg::REG_MERGE_THR, 32'h00001000);
    test_random_pixels(100, 0, 0);
    write_reg(spknn_pkg::REG_SIDE_LEN, 1024);
    write_reg(spknn_pkg::REG_MERGE_THR, 32'h00800000);
    test_random_pixels(100, 88, 0);
    write_reg(spknn_pkg::REG_SIDE_LEN, 1);
    write_reg(spknn_pkg::REG_MERGE_THR, 32'h00000000);
    test_random_pixels(100, 0, 88);
    write_reg(spknn_pkg::REG_SIDE_LEN, 5);
    write_reg(spknn_pkg::REG_MERGE_THR, 32'h00002000);
    test_random_pixels(100, 33, 33);
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
